// ===== hdl/orl_pkg.sv =====
`timescale 1ns / 1ps

package orl_pkg;

	// Default table depth
	localparam int CAPACITY_DEF = 16;

	// Field widths
	localparam int ACT_W   = 3;
	localparam int POS_W   = 5;
	localparam int KEY_W   = 32;
	localparam int AGE_W   = 10;
	localparam int TAG_W   = 64;
	localparam int ST_W    = 3;
	localparam int COUNT_W = 5;

	// Action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT  = 3'd0,
		ACT_DELETE  = 3'd1,
		ACT_FIND    = 3'd2,
		ACT_REWRITE = 3'd3,
		ACT_LIST    = 3'd4,
		ACT_CLEAR   = 3'd5
	} action_t;

	// Result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_BAD_POS   = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_KEY   = 3'd4
	} status_t;

	// One stored record
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
		logic [TAG_W-1:0] tag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

endpackage

// ===== hdl/orl_ram.sv =====
`timescale 1ns / 1ps

module orl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port, registered read port; read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/ordered_record_list_top.sv =====
`timescale 1ns / 1ps

// Ordered record table: up to CAPACITY records (key, age, tag) kept in order.
// Input channel (in_valid/in_ready) carries one action per transaction:
// insert at a 1-based position, delete / find / rewrite the first entry with
// a key, list all entries, or clear. Action codes six and seven are taken and
// dropped without a result. Output channel (out_valid/out_ready) carries the
// results: one per action, one per entry for list, last set on the final one.
// One action is worked at a time; in_ready is high only when the engine idles.
// All records sit in one single-port-write RAM with a registered read, and
// each action walks the RAM (n = entry count, s = slot):
//   find / rewrite / not found : scan from entry 0, one entry read per cycle
//   delete : scan for the key, then shift the later entries down
//   insert : shift entries s to n-1 up, then write the new one; append writes it
//   list   : read entries in order from entry 0, one result per cycle while out_ready stays high
//   errors and clear : no RAM access, result only
// A stalled receiver holds the one-deep output register; the engine then
// stalls in place and the RAM read data holds until the result is taken.
// Reset empties the table (count zero); RAM contents need no clearing.
module ordered_record_list_top
	import orl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ACT_W-1:0]   action,
	input  logic [POS_W-1:0]   position,
	input  logic [KEY_W-1:0]   key,
	input  logic [KEY_W-1:0]   new_key,
	input  logic [AGE_W-1:0]   age,
	input  logic [TAG_W-1:0]   record_tag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ST_W-1:0]    status,
	output logic [KEY_W-1:0]   key_res,
	output logic [AGE_W-1:0]   age_res,
	output logic [TAG_W-1:0]   record_tag_res,
	output logic [COUNT_W-1:0] entry_count,
	output logic               last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHUP,
		S_SHDN,
		S_PUT,
		S_LIST,
		S_ERR
	} state_t;

	state_t           state_q;
	action_t          act_q;
	status_t          err_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] nkey_q;
	logic [AGE_W-1:0] age_q;
	logic [TAG_W-1:0] tag_q;
	logic [AW-1:0]    slot_q;
	logic [CW-1:0]    idx_q;
	logic             issue_q;
	logic [CW-1:0]    count_q;
	logic             valid_s1;
	logic [AW-1:0]    idx_s1;

	logic               out_valid_q;
	status_t            status_q;
	rec_t               res_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic               last_q;

	logic          in_acc;
	logic          out_free;
	logic          more;
	logic          hit;
	logic          miss;
	logic          list_last;
	rec_t          rd_rec;
	rec_t          new_rec;
	logic [REC_W-1:0] rd_data;
	logic          rd_en;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	rec_t          wr_rec;

	logic          emit_en;
	status_t       emit_st;
	rec_t          emit_rec;
	logic [CW-1:0] emit_cnt;
	logic          emit_last;

	logic [PW-1:0] pos_x;
	logic [PW-1:0] cnt_x;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign rd_rec    = rec_t'(rd_data);
	assign more      = (idx_q < count_q);
	assign hit       = valid_s1 && (rd_rec.key == key_q);
	assign miss      = !valid_s1 && !more;
	assign list_last = ((CW'(idx_s1) + CW'(1)) == count_q);
	assign pos_x     = PW'(position);
	assign cnt_x     = PW'(count_q);

	assign new_rec.key = (act_q == ACT_REWRITE) ? nkey_q : key_q;
	assign new_rec.age = age_q;
	assign new_rec.tag = tag_q;

	// Drive RAM ports by engine state
	always_comb begin
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_rec  = new_rec;
		unique case (state_q)
			S_SCAN: begin
				rd_en   = more && !hit;
				wr_en   = hit && out_free && (act_q == ACT_REWRITE);
				wr_addr = idx_s1;
			end
			S_LIST: begin
				rd_en = more && !(valid_s1 && !out_free);
			end
			S_SHUP: begin
				rd_en   = issue_q;
				wr_en   = valid_s1;
				wr_addr = idx_s1 + AW'(1);
				wr_rec  = rd_rec;
			end
			S_SHDN: begin
				rd_en   = (idx_q <= count_q);
				wr_en   = valid_s1;
				wr_addr = idx_s1 - AW'(1);
				wr_rec  = rd_rec;
			end
			S_PUT: begin
				wr_en = out_free;
			end
			S_IDLE, S_ERR: begin
			end
			default: begin
			end
		endcase
	end

	orl_ram #(
		.WIDTH(REC_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (REC_W'(wr_rec)),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Select the result to load into the output register
	always_comb begin
		emit_en   = 1'b0;
		emit_st   = ST_OK;
		emit_rec  = '0;
		emit_cnt  = count_q;
		emit_last = 1'b1;
		unique case (state_q)
			S_ERR: begin
				emit_en = out_free;
				emit_st = err_q;
			end
			S_SCAN: begin
				if (hit) begin
					emit_en  = out_free;
					emit_rec = (act_q == ACT_REWRITE) ? new_rec : rd_rec;
					if (act_q == ACT_DELETE) begin
						emit_cnt = count_q - CW'(1);
					end
				end else if (miss) begin
					emit_en = out_free;
					emit_st = ST_NOT_FOUND;
				end
			end
			S_PUT: begin
				emit_en  = out_free;
				emit_rec = new_rec;
				emit_cnt = count_q + CW'(1);
			end
			S_LIST: begin
				emit_en   = valid_s1 && out_free;
				emit_rec  = rd_rec;
				emit_last = list_last;
			end
			S_IDLE, S_SHUP, S_SHDN: begin
			end
			default: begin
			end
		endcase
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			status_q      <= emit_st;
			res_q         <= emit_rec;
			entry_count_q <= COUNT_W'(emit_cnt);
			last_q        <= emit_last;
		end
	end

	// Sequence one action through the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			issue_q  <= 1'b0;
			idx_q    <= '0;
			idx_s1   <= '0;
			slot_q   <= '0;
			err_q    <= ST_OK;
			act_q    <= ACT_INSERT;
			key_q    <= '0;
			nkey_q   <= '0;
			age_q    <= '0;
			tag_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						key_q  <= key;
						nkey_q <= new_key;
						age_q  <= age;
						tag_q  <= record_tag;
						idx_q  <= '0;
						unique case (action)
							ACT_INSERT: begin
								act_q  <= ACT_INSERT;
								slot_q <= AW'(position - POS_W'(1));
								if (count_q == CW'(CAPACITY)) begin
									err_q   <= ST_FULL;
									state_q <= S_ERR;
								end else if (position == '0 || pos_x > cnt_x + PW'(1)) begin
									err_q   <= ST_BAD_POS;
									state_q <= S_ERR;
								end else if (pos_x == cnt_x + PW'(1)) begin
									state_q <= S_PUT;
								end else begin
									idx_q   <= count_q - CW'(1);
									issue_q <= 1'b1;
									state_q <= S_SHUP;
								end
							end
							ACT_DELETE: begin
								act_q <= ACT_DELETE;
								if (key == '0) begin
									err_q   <= ST_BAD_KEY;
									state_q <= S_ERR;
								end else begin
									state_q <= S_SCAN;
								end
							end
							ACT_FIND: begin
								act_q   <= ACT_FIND;
								state_q <= S_SCAN;
							end
							ACT_REWRITE: begin
								act_q   <= ACT_REWRITE;
								state_q <= S_SCAN;
							end
							ACT_LIST: begin
								act_q <= ACT_LIST;
								if (count_q == '0) begin
									err_q   <= ST_BAD_KEY;
									state_q <= S_ERR;
								end else begin
									state_q <= S_LIST;
								end
							end
							ACT_CLEAR: begin
								act_q   <= ACT_CLEAR;
								count_q <= '0;
								err_q   <= ST_OK;
								state_q <= S_ERR;
							end
							default: begin
							end
						endcase
					end
				end
				S_ERR: begin
					if (emit_en) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (hit) begin
						// Hold the read data on a stall; finish on a free output
						if (out_free) begin
							valid_s1 <= 1'b0;
							if (act_q == ACT_DELETE) begin
								count_q <= count_q - CW'(1);
								idx_q   <= CW'(idx_s1) + CW'(1);
								state_q <= S_SHDN;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end else if (miss) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						valid_s1 <= rd_en;
						idx_s1   <= idx_q[AW-1:0];
						if (rd_en) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				S_SHUP: begin
					valid_s1 <= issue_q;
					idx_s1   <= idx_q[AW-1:0];
					if (issue_q) begin
						if (idx_q[AW-1:0] == slot_q) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q - CW'(1);
						end
					end else if (!valid_s1) begin
						state_q <= S_PUT;
					end
				end
				S_SHDN: begin
					valid_s1 <= rd_en;
					idx_s1   <= idx_q[AW-1:0];
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end else if (!valid_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_PUT: begin
					if (out_free) begin
						count_q <= count_q + CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (!valid_s1 || out_free) begin
						valid_s1 <= rd_en;
						idx_s1   <= idx_q[AW-1:0];
					end
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (emit_en && list_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign key_res        = res_q.key;
	assign age_res        = res_q.age;
	assign record_tag_res = res_q.tag;
	assign entry_count    = entry_count_q;
	assign last           = last_q;

	// Table never holds more than its capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// No read is in flight while the engine idles
	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !valid_s1)
		else $error("read pipeline busy in idle");

	// A result is only loaded into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	// Clear empties the table on the next cycle
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == ACT_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the table");

endmodule

// ===== tb/sv/orl_tb_pkg.sv =====
`timescale 1ns / 1ps

package orl_tb_pkg;
	import orl_pkg::*;

	// One result transaction as seen on the output channel
	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [KEY_W-1:0]   key;
		logic [AGE_W-1:0]   age;
		logic [TAG_W-1:0]   tag;
		logic [COUNT_W-1:0] entry_count;
		logic               last;
	} outcome_t;

	// Shadow copy of the record table plus the results it still owes
	class record_roster;
		int unsigned      depth;
		int unsigned      fill;
		logic [KEY_W-1:0] keys[];
		logic [AGE_W-1:0] ages[];
		logic [TAG_W-1:0] tags[];
		outcome_t         due[$];
		int unsigned      faults;

		function new(int unsigned cap);
			depth  = cap;
			keys   = new[cap];
			ages   = new[cap];
			tags   = new[cap];
			fill   = 0;
			faults = 0;
		endfunction

		// Queue one result; entry fields come from a slot or stay zero
		function void queue_outcome(logic [ST_W-1:0] st, int slot, bit use_slot, bit is_last);
			outcome_t o;
			o = '0;
			o.status = st;
			if (use_slot) begin
				o.key = keys[slot];
				o.age = ages[slot];
				o.tag = tags[slot];
			end
			o.entry_count = COUNT_W'(fill);
			o.last = is_last;
			due.push_back(o);
		endfunction

		// First slot holding k, or -1
		function int lookup(logic [KEY_W-1:0] k);
			for (int i = 0; i < fill; i++)
				if (keys[i] == k)
					return i;
			return -1;
		endfunction

		// Update the table for one accepted action and queue its results
		function void apply_action(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
				logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk, logic [AGE_W-1:0] a,
				logic [TAG_W-1:0] t);
			int slot;
			outcome_t gone;
			case (act)
				ACT_INSERT: begin
					// fullness wins over a bad position
					if (fill >= depth) begin
						queue_outcome(ST_FULL, 0, 0, 1);
					end else if (pos < 1 || pos > fill + 1) begin
						queue_outcome(ST_BAD_POS, 0, 0, 1);
					end else begin
						slot = pos - 1;
						for (int i = fill; i > slot; i--) begin
							keys[i] = keys[i-1];
							ages[i] = ages[i-1];
							tags[i] = tags[i-1];
						end
						keys[slot] = k;
						ages[slot] = a;
						tags[slot] = t;
						fill++;
						queue_outcome(ST_OK, slot, 1, 1);
					end
				end
				ACT_DELETE: begin
					slot = lookup(k);
					if (k == '0) begin
						queue_outcome(ST_BAD_KEY, 0, 0, 1);
					end else if (slot < 0) begin
						queue_outcome(ST_NOT_FOUND, 0, 0, 1);
					end else begin
						// report the removed entry, then close the gap
						gone = '0;
						gone.status = ST_OK;
						gone.key = keys[slot];
						gone.age = ages[slot];
						gone.tag = tags[slot];
						for (int i = slot; i + 1 < fill; i++) begin
							keys[i] = keys[i+1];
							ages[i] = ages[i+1];
							tags[i] = tags[i+1];
						end
						fill--;
						gone.entry_count = COUNT_W'(fill);
						gone.last = 1'b1;
						due.push_back(gone);
					end
				end
				ACT_FIND: begin
					slot = lookup(k);
					if (slot < 0)
						queue_outcome(ST_NOT_FOUND, 0, 0, 1);
					else
						queue_outcome(ST_OK, slot, 1, 1);
				end
				ACT_REWRITE: begin
					slot = lookup(k);
					if (slot < 0) begin
						queue_outcome(ST_NOT_FOUND, 0, 0, 1);
					end else begin
						keys[slot] = nk;
						ages[slot] = a;
						tags[slot] = t;
						queue_outcome(ST_OK, slot, 1, 1);
					end
				end
				ACT_LIST: begin
					if (fill == 0)
						queue_outcome(ST_BAD_KEY, 0, 0, 1);
					else
						for (int i = 0; i < fill; i++)
							queue_outcome(ST_OK, i, 1, i + 1 == fill);
				end
				ACT_CLEAR: begin
					fill = 0;
					queue_outcome(ST_OK, 0, 0, 1);
				end
				default: begin
					// spare action codes: dropped without a result
				end
			endcase
		endfunction

		// Compare one output transaction against the oldest expected result
		function void match_result(outcome_t got);
			outcome_t want;
			if (due.size() == 0) begin
				$display("%0t: unexpected result: status=%0d key=%h age=%0d tag=%h count=%0d last=%b",
					$time, got.status, got.key, got.age, got.tag, got.entry_count, got.last);
				faults++;
				return;
			end
			want = due.pop_front();
			if (got !== want) begin
				$display("%0t: result mismatch", $time);
				$display("  expected status=%0d key=%h age=%0d tag=%h count=%0d last=%b",
					want.status, want.key, want.age, want.tag, want.entry_count, want.last);
				$display("  actual   status=%0d key=%h age=%0d tag=%h count=%0d last=%b",
					got.status, got.key, got.age, got.tag, got.entry_count, got.last);
				faults++;
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_ordered_record_list_top.sv =====
`timescale 1ns / 1ps

module tb_ordered_record_list_top;
	import orl_pkg::*;
	import orl_tb_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_CYCLES  = 160;
	localparam int RANDOM_ITEMS = 110;
	localparam int QUIET_TAIL   = 20;
	localparam int DRAIN_CYCLES = 40;

	// Action codes outside the defined set; the block drops them
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [ACT_W-1:0]   action;
	logic [POS_W-1:0]   position;
	logic [KEY_W-1:0]   key;
	logic [KEY_W-1:0]   new_key;
	logic [AGE_W-1:0]   age;
	logic [TAG_W-1:0]   record_tag;
	logic               out_valid;
	logic               out_ready;
	logic [ST_W-1:0]    status;
	logic [KEY_W-1:0]   key_res;
	logic [AGE_W-1:0]   age_res;
	logic [TAG_W-1:0]   record_tag_res;
	logic [COUNT_W-1:0] entry_count;
	logic               last;

	record_roster roster;
	bit           calm = 1'b0;
	bit           hold_req = 1'b0;
	int unsigned  idle_cycles = 0;

	ordered_record_list_top #(
		.CAPACITY(CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.position(position),
		.key(key),
		.new_key(new_key),
		.age(age),
		.record_tag(record_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.key_res(key_res),
		.age_res(age_res),
		.record_tag_res(record_tag_res),
		.entry_count(entry_count),
		.last(last)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Check every accepted result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			roster.match_result(outcome_t'({status, key_res, age_res, record_tag_res,
				entry_count, last}));
	end

	// Drive out_ready: random bursts, one long hold-off on request, always ready when calm
	initial begin
		int unsigned span;
		out_ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				span = $urandom_range(1, 16);
				out_ready <= ($urandom_range(0, 2) != 0);
				repeat (span) @(posedge clk);
			end
		end
	end

	// Drop in_valid for a random burst, now and then
	task automatic sender_gap();
		int unsigned span;
		if (calm || hold_req || $urandom_range(0, 2) != 0)
			return;
		span = $urandom_range(1, 16);
		in_valid <= 1'b0;
		repeat (span) @(posedge clk);
	endtask

	// Offer one action, hold it until accepted, then note it in the roster
	task automatic offer(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
			logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk, logic [AGE_W-1:0] a,
			logic [TAG_W-1:0] t);
		action     <= act;
		position   <= pos;
		key        <= k;
		new_key    <= nk;
		age        <= a;
		record_tag <= t;
		in_valid   <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		roster.apply_action(act, pos, k, nk, a, t);
		sender_gap();
	endtask

	// Key to store: small pool for duplicates, a stored key, or anything
	function automatic logic [KEY_W-1:0] fresh_key();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return KEY_W'($urandom_range(0, 3));
		if (r < 5 && roster.fill > 0)
			return roster.keys[$urandom_range(0, roster.fill - 1)];
		return $urandom;
	endfunction

	// Key to look up: mostly one that is stored
	function automatic logic [KEY_W-1:0] lookup_key();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6 && roster.fill > 0)
			return roster.keys[$urandom_range(0, roster.fill - 1)];
		if (r < 8)
			return KEY_W'($urandom_range(0, 3));
		return $urandom;
	endfunction

	// Mostly a valid insert position, sometimes any 5-bit value
	function automatic logic [POS_W-1:0] pick_position();
		if (roster.fill < CAP && $urandom_range(0, 9) < 8)
			return POS_W'($urandom_range(1, roster.fill + 1));
		return POS_W'($urandom_range(0, 31));
	endfunction

	// Build and offer one random action; counted is clear for dropped codes
	task automatic random_item(bit fill_mode, output bit counted);
		int unsigned      r;
		logic [ACT_W-1:0] act;
		logic [KEY_W-1:0] k;
		r = $urandom_range(0, 99);
		if (fill_mode || r < 40 || r >= 96)
			act = ACT_INSERT;
		else if (r < 55)
			act = ACT_DELETE;
		else if (r < 68)
			act = ACT_FIND;
		else if (r < 80)
			act = ACT_REWRITE;
		else if (r < 87)
			act = ACT_LIST;
		else if (r < 91)
			act = ACT_CLEAR;
		else
			act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
		k = (act == ACT_INSERT) ? fresh_key() : lookup_key();
		counted = (act <= ACT_CLEAR);
		offer(act, pick_position(), k, fresh_key(), AGE_W'($urandom_range(0, 1023)),
			{$urandom, $urandom});
	endtask

	// Reset, directed actions, random actions, drain
	initial begin
		int unsigned sent;
		int unsigned fill_left;
		bit          counted;
		bit          held;
		roster = new(CAP);
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_INSERT;
		position   <= '0;
		key        <= '0;
		new_key    <= '0;
		age        <= '0;
		record_tag <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-table errors and corner positions
		offer(ACT_LIST, 5'd1, '0, '0, '0, '0);
		offer(ACT_DELETE, 5'd1, '0, '0, '0, '0);
		offer(ACT_FIND, 5'd1, '0, '0, '0, '0);
		offer(ACT_REWRITE, 5'd1, 32'd5, 32'd6, 10'd1, 64'h1);
		offer(ACT_INSERT, 5'd0, 32'h1234, '0, 10'd3, 64'h3);
		offer(ACT_INSERT, 5'd2, 32'h1234, '0, 10'd3, 64'h3);
		offer(ACT_INSERT, 5'd1, '1, '0, '1, '1);
		offer(ACT_INSERT, 5'd2, '0, '0, '0, '0);
		offer(ACT_INSERT, 5'd1, 32'd7, '0, 10'd999, 64'hA5A5_5A5A_0F0F_F0F0);
		offer(ACT_INSERT, '1, 32'd9, '0, 10'd9, 64'h9);
		// key zero is an ordinary lookup for find and rewrite
		offer(ACT_FIND, 5'd1, '0, '0, '0, '0);
		offer(ACT_REWRITE, 5'd1, '0, 32'h8000_0000, 10'd512, 64'h8000_0000_0000_0001);
		offer(ACT_DELETE, 5'd1, 32'd7, '0, '0, '0);
		offer(ACT_DELETE, 5'd1, 32'd7, '0, '0, '0);
		offer(ACT_SPARE_LO, '1, '1, '1, '1, '1);
		offer(ACT_SPARE_HI, '1, '1, '1, '1, '1);
		offer(ACT_LIST, 5'd1, '0, '0, '0, '0);
		// duplicate key: lookups hit the first one
		offer(ACT_INSERT, 5'd3, '1, '0, 10'd0, 64'h5);
		offer(ACT_FIND, 5'd1, '1, '0, '0, '0);
		offer(ACT_REWRITE, 5'd1, '1, 32'h1, 10'd77, 64'h77);
		offer(ACT_DELETE, 5'd1, '1, '0, '0, '0);
		offer(ACT_CLEAR, 5'd1, '0, '0, '0, '0);
		offer(ACT_LIST, 5'd1, '0, '0, '0, '0);

		// random actions, with two runs that fill the table past full
		sent = 0;
		fill_left = 0;
		held = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= RANDOM_ITEMS - QUIET_TAIL);
			if (!held && sent == 55) begin
				// stall the receiver while the sender keeps offering
				held = 1'b1;
				hold_req = 1'b1;
			end
			random_item(fill_left != 0, counted);
			if (fill_left != 0)
				fill_left--;
			if (counted) begin
				sent++;
				if (sent == 45 || sent == 80)
					fill_left = CAP - roster.fill + 2;
			end
		end
		in_valid <= 1'b0;

		// drain the expected results, then watch for strays
		while (roster.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (roster.faults == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/orl_pkg.sv
hdl/orl_ram.sv
hdl/ordered_record_list_top.sv
tb/sv/orl_tb_pkg.sv
tb/sv/tb_ordered_record_list_top.sv
